[rtl/aopb_pkg.sv]
// Shared types and constants for the alpha-over pixel blend pipeline.
`default_nettype none

package aopb_pkg;

    localparam int CHAN_W  = 8;
    localparam int NUM_CH  = 3;
    localparam int DEN_W   = 16;
    localparam int PROD_W  = 24;
    localparam int NUM_W   = 25;
    localparam int PIX_W   = 32;
    localparam int AX_W    = 17;
    localparam int QUO_W   = 8;

    localparam logic [CHAN_W-1:0] FULL     = 8'd255;
    localparam logic [DEN_W-1:0]  FULL_SQ  = 16'd65025;
    localparam logic [CHAN_W-1:0] HALF     = 8'd127;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [DEN_W-1:0]  den_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [PIX_W-1:0]  pix_t;

    // after clamp and alpha math
    typedef struct packed {
        logic                     pass;
        pix_t                     dest;
        den_t                     den;
        den_t                     t;
        chan_t [NUM_CH-1:0]       sc;
        chan_t [NUM_CH-1:0]       dc;
    } prep_t;

    // after the colour products
    typedef struct packed {
        logic                     pass;
        pix_t                     dest;
        den_t                     den;
        logic [AX_W-1:0]          ax;
        chan_t                    aq0;
        prod_t [NUM_CH-1:0]       p1;
        prod_t [NUM_CH-1:0]       p2;
    } prod_stage_t;

    // divider pipeline word
    typedef struct packed {
        logic                     pass;
        pix_t                     dest;
        chan_t                    abyte;
        den_t                     den;
        num_t  [NUM_CH-1:0]       rem;
        chan_t [NUM_CH-1:0]       quo;
        logic  [NUM_CH-1:0]       sat;
    } div_t;

endpackage

`default_nettype wire

[rtl/aopb_prep.sv]
// Stage 1: source colour clamp, scaled output alpha and destination weight.
`default_nettype none

module aopb_prep (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire aopb_pkg::pix_t  src,
    input  wire aopb_pkg::pix_t  dst,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output aopb_pkg::prep_t      out_data
);
    import aopb_pkg::*;

    chan_t sa;
    chan_t da;
    chan_t inv_sa;
    den_t  sa_full;
    prep_t data_next;
    prep_t data_reg;
    logic  vld_reg;

    always_comb begin
        sa      = src[PIX_W-1 -: CHAN_W];
        da      = dst[PIX_W-1 -: CHAN_W];
        inv_sa  = FULL - sa;
        sa_full = {sa, CHAN_W'(0)} - DEN_W'(sa);

        data_next.pass = (sa == '0);
        data_next.dest = dst;
        data_next.t    = DEN_W'(da) * DEN_W'(inv_sa);
        data_next.den  = sa_full + data_next.t;
        for (int c = 0; c < NUM_CH; c++) begin
            data_next.sc[c] = (src[c*CHAN_W +: CHAN_W] > sa) ? sa : src[c*CHAN_W +: CHAN_W];
            data_next.dc[c] = dst[c*CHAN_W +: CHAN_W];
        end
    end

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/aopb_mul.sv]
// Stages 2 and 3: colour products, rounded numerators, saturation check, alpha byte.
`default_nettype none

module aopb_mul (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire aopb_pkg::prep_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output aopb_pkg::div_t       out_data
);
    import aopb_pkg::*;

    prod_stage_t     prod_next;
    prod_stage_t     prod_reg;
    logic            prod_vld_reg;
    logic            prod_ready;
    logic [AX_W-1:0] ax_sum;
    logic [AX_W-1:0] ax_rem;
    div_t            sum_next;
    div_t            sum_reg;
    logic            sum_vld_reg;
    num_t            n_c;

    // products; alpha byte estimate (x*257)>>16, at most one short of x/255
    always_comb begin
        prod_next.pass = in_data.pass;
        prod_next.dest = in_data.dest;
        prod_next.den  = in_data.den;
        prod_next.ax   = AX_W'(in_data.den) + AX_W'(HALF);
        ax_sum         = prod_next.ax + (prod_next.ax >> CHAN_W);
        prod_next.aq0  = ax_sum[2*CHAN_W-1:CHAN_W];
        for (int c = 0; c < NUM_CH; c++) begin
            prod_next.p1[c] = PROD_W'(in_data.sc[c]) * PROD_W'(FULL_SQ);
            prod_next.p2[c] = PROD_W'(in_data.dc[c]) * PROD_W'(in_data.t);
        end
    end

    assign in_ready = !prod_vld_reg || prod_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else if (in_ready) begin
            prod_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            prod_reg <= prod_next;
        end
    end

    // numerator sums, overflow test against den*256, alpha correction
    always_comb begin
        n_c            = '0;
        ax_rem         = prod_reg.ax - (AX_W'({prod_reg.aq0, CHAN_W'(0)}) - AX_W'(prod_reg.aq0));
        sum_next.pass  = prod_reg.pass;
        sum_next.dest  = prod_reg.dest;
        sum_next.den   = prod_reg.den;
        sum_next.abyte = (ax_rem >= AX_W'(FULL)) ? (prod_reg.aq0 + CHAN_W'(1)) : prod_reg.aq0;
        for (int c = 0; c < NUM_CH; c++) begin
            n_c = NUM_W'(prod_reg.p1[c]) + NUM_W'(prod_reg.p2[c])
                + NUM_W'(prod_reg.den >> 1);
            sum_next.rem[c] = n_c;
            sum_next.quo[c] = '0;
            sum_next.sat[c] = (n_c >= (NUM_W'(prod_reg.den) << QUO_W));
        end
    end

    assign prod_ready = !sum_vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg <= 1'b0;
        end else if (prod_ready) begin
            sum_vld_reg <= prod_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && prod_vld_reg) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_vld_reg;
    assign out_data  = sum_reg;

endmodule

`default_nettype wire

[rtl/aopb_div_step.sv]
// One restoring-division stage: resolves one quotient bit for all three colours.
`default_nettype none

module aopb_div_step #(
    parameter int BIT = 7
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire aopb_pkg::div_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output aopb_pkg::div_t      out_data
);
    import aopb_pkg::*;

    num_t trial;
    div_t data_next;
    div_t data_reg;
    logic vld_reg;

    always_comb begin
        trial     = NUM_W'(in_data.den) << BIT;
        data_next = in_data;
        for (int c = 0; c < NUM_CH; c++) begin
            if (in_data.rem[c] >= trial) begin
                data_next.rem[c]      = in_data.rem[c] - trial;
                data_next.quo[c][BIT] = 1'b1;
            end
        end
    end

    assign in_ready = !vld_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[rtl/alpha_over_pixel_blend_core.sv]
// Top level: Porter-Duff "over" compositing of ARGB8888 pixels, one word per clock while m_ready is high.
//
// Channels: s_ (valid/ready) carries s_source_pixel (premultiplied ARGB, colours
// clamped to alpha here) and s_dest_pixel (straight ARGB). m_ (valid/ready)
// carries m_blended_pixel (straight ARGB). A word is taken when valid and ready
// are both high on a rising aclk edge.
// Pipeline: 1 prep stage, 2 multiply/sum stages, 8 divider stages (one quotient
// bit each) = 11 registers; a taken word passes through the prep, product, sum
// and divider registers in that order before it reaches m_blended_pixel.
// Throughput: one word per clock while m_ready is high; set by the fully pipelined bit-per-stage divider.
// Stall: each stage holds while the next is full; bubbles are squeezed out, so
// s_ready drops only when all 11 stages hold words and m_ready is low. Nothing
// is dropped or duplicated.
// Reset: synchronous, active-low aresetn clears every stage valid bit; the
// pipeline comes out empty with s_ready high.
// Source alpha zero: the destination word passes through unchanged.
// Colour quotients above 255 saturate; the saturation test runs before the divider.
`default_nettype none

module alpha_over_pixel_blend_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire aopb_pkg::pix_t s_source_pixel,
    input  wire aopb_pkg::pix_t s_dest_pixel,
    output logic                m_valid,
    input  wire logic           m_ready,
    output aopb_pkg::pix_t      m_blended_pixel
);
    import aopb_pkg::*;

    localparam int NSTEP = QUO_W;

    prep_t prep_data;
    logic  prep_valid;
    logic  prep_ready;

    div_t  div_data  [0:NSTEP];
    logic  div_valid [0:NSTEP];
    logic  div_ready [0:NSTEP];

    div_t  last;
    pix_t  blend_word;

    aopb_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .src       (s_source_pixel),
        .dst       (s_dest_pixel),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    aopb_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_data  (div_data[0])
    );

    // quotient bits MSB first
    for (genvar g = 0; g < NSTEP; g++) begin : g_div
        aopb_div_step #(
            .BIT (NSTEP - 1 - g)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_ready (div_ready[g+1]),
            .out_data  (div_data[g+1])
        );
    end

    assign last             = div_data[NSTEP];
    assign div_ready[NSTEP] = m_ready;
    assign m_valid          = div_valid[NSTEP];

    // final word: pass-through or {alpha, saturated colours}
    always_comb begin
        blend_word = '0;
        blend_word[PIX_W-1 -: CHAN_W] = last.abyte;
        for (int c = 0; c < NUM_CH; c++) begin
            blend_word[c*CHAN_W +: CHAN_W] = last.sat[c] ? FULL : last.quo[c];
        end
    end

    assign m_blended_pixel = last.pass ? last.dest : blend_word;

    // a blended word with nonzero source alpha always has nonzero output alpha
    a_alpha_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !last.pass) |-> (last.abyte != '0))
        else $error("blend: output alpha zero with nonzero source alpha");

    // unsaturated quotients leave a remainder below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !last.pass) |->
            ((last.sat[0] || (last.rem[0] < NUM_W'(last.den))) &&
             (last.sat[1] || (last.rem[1] < NUM_W'(last.den))) &&
             (last.sat[2] || (last.rem[2] < NUM_W'(last.den)))))
        else $error("blend: divider remainder out of range");

    // input stalls only when the prep, sum and last divider stages are full and the output is blocked
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && prep_valid && div_valid[0]))
        else $error("blend: input stalled with room in pipeline");

endmodule

`default_nettype wire
